// ===== sv/pl0bt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0bt_pkg
// Shared widths, token kinds, error codes, result types and the keyword
// spelling table of the PL/0 byte tokenizer.
// ----------------------------------------------------------------------------
package pl0bt_pkg;

    localparam int MAX_TOKEN_BYTES = 32;
    localparam int NUMBER_BITS     = 31;
    localparam int LINE_BITS       = 20;
    localparam int OFFSET_BITS     = 24;
    localparam int LENGTH_BITS     = 6;
    localparam int KIND_BITS       = 5;
    localparam int ERROR_BITS      = 3;

    localparam int KEYWORDS        = 11;
    localparam int KW_MAX_CHARS    = 9;
    localparam int KW_CHAR_BITS    = $clog2(KW_MAX_CHARS);
    localparam int KW_LEN_BITS     = 5;

    typedef logic [KIND_BITS-1:0]  kind_t;
    typedef logic [ERROR_BITS-1:0] err_t;

    localparam kind_t KIND_END       = 5'd0;
    localparam kind_t KIND_IDENT     = 5'd1;
    localparam kind_t KIND_NUMBER    = 5'd2;
    localparam kind_t KIND_KW_BASE   = 5'd3;
    localparam kind_t KIND_PERIOD    = 5'd14;
    localparam kind_t KIND_EQUAL     = 5'd15;
    localparam kind_t KIND_COMMA     = 5'd16;
    localparam kind_t KIND_SEMICOLON = 5'd17;
    localparam kind_t KIND_HASH      = 5'd18;
    localparam kind_t KIND_LESS      = 5'd19;
    localparam kind_t KIND_GREATER   = 5'd20;
    localparam kind_t KIND_PLUS      = 5'd21;
    localparam kind_t KIND_MINUS     = 5'd22;
    localparam kind_t KIND_TIMES     = 5'd23;
    localparam kind_t KIND_SLASH     = 5'd24;
    localparam kind_t KIND_LPAREN    = 5'd25;
    localparam kind_t KIND_RPAREN    = 5'd26;
    localparam kind_t KIND_ASSIGN    = 5'd27;
    localparam kind_t KIND_ERROR     = 5'd28;

    localparam err_t ERR_NONE         = 3'd0;
    localparam err_t ERR_UNKNOWN_BYTE = 3'd1;
    localparam err_t ERR_BAD_COLON    = 3'd2;
    localparam err_t ERR_OPEN_COMMENT = 3'd3;
    localparam err_t ERR_OVERFLOW     = 3'd4;

    // Keyword characters as offsets from U+0900. Every character is three
    // UTF-8 bytes: E0, A4 or A5, then 80 plus the low six bits.
    typedef logic [6:0] kw_char_t;

    localparam kw_char_t KW_CHARS [KEYWORDS][KW_MAX_CHARS] = '{
        '{7'h28, 7'h3F, 7'h2F, 7'h24, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h1A, 7'h30, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h2A, 7'h4D, 7'h30, 7'h15, 7'h4D, 7'h30, 7'h3F, 7'h2F, 7'h3E},
        '{7'h06, 7'h39, 7'h4D, 7'h35, 7'h3E, 7'h28, 7'h00, 7'h00, 7'h00},
        '{7'h06, 7'h30, 7'h2E, 7'h4D, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h38, 7'h2E, 7'h3E, 7'h2A, 7'h28, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h2F, 7'h26, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h24, 7'h4B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h1C, 7'h2C, 7'h24, 7'h15, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h15, 7'h30, 7'h4B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h35, 7'h3F, 7'h37, 7'h2E, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    // Keyword lengths in bytes.
    localparam logic [KW_LEN_BITS-1:0] KW_BYTES [KEYWORDS] = '{
        5'd12, 5'd6, 5'd27, 5'd18, 5'd15, 5'd15, 5'd9, 5'd6, 5'd12, 5'd9, 5'd12
    };

    typedef struct packed {
        kind_t                   kind;
        logic [LINE_BITS-1:0]    line;
        logic [OFFSET_BITS-1:0]  offset;
        logic [LENGTH_BITS-1:0]  length;
        logic [NUMBER_BITS-1:0]  value;
        err_t                    error;
    } result_t;

    // All results caused by one source byte.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    pair;
    } entry_t;

endpackage

// ===== sv/pl0bt_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0bt_scan
// Scanner state and the per-byte decode: takes one registered byte per step
// and forms the zero, one or two results that the byte causes.
// ----------------------------------------------------------------------------
module pl0bt_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    output pl0bt_pkg::entry_t entry,
    output logic [1:0]        count
);
    import pl0bt_pkg::*;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_IDENT   = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_COLON   = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_ERROR   = 6'b100000
    } mode_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = LENGTH_BITS'(MAX_TOKEN_BYTES);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE   = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO   = LENGTH_BITS'(2);
    localparam logic [LINE_BITS-1:0]   LINE_ONE  = LINE_BITS'(1);
    localparam int                     PROD_BITS = NUMBER_BITS + 4;
    localparam logic [KW_CHAR_BITS-1:0] CI_LAST  = KW_CHAR_BITS'(KW_MAX_CHARS - 1);

    mode_t                    mode_reg,  mode_next, mode_mid;
    logic [KEYWORDS-1:0]      alive_reg, alive_next;
    logic [LENGTH_BITS-1:0]   run_reg,   run_next;
    logic [KW_CHAR_BITS-1:0]  ci_reg,    ci_next;
    logic [1:0]               ph_reg,    ph_next;
    logic [NUMBER_BITS-1:0]   accum_reg, accum_next;
    logic                     ovf_reg,   ovf_next;
    logic [LINE_BITS-1:0]     line_reg,  line_next;
    logic [OFFSET_BITS-1:0]   pos_reg,   pos_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;

    logic                     is_digit, is_alpha;
    logic                     consumed, fresh, take_ident, take_number;
    logic                     restart, new_line;
    logic                     p1_valid, p2_valid, p2_pair;
    result_t                  p1_res, p2_res_a, p2_res_b;
    kind_t                    kw_kind, punct_kind;
    logic                     punct_hit;

    logic [LENGTH_BITS-1:0]   run_base;
    logic [KW_CHAR_BITS-1:0]  ci_base;
    logic [1:0]               ph_base;
    logic [KEYWORDS-1:0]      alive_base, kw_match;
    logic [NUMBER_BITS-1:0]   accum_base;
    logic [PROD_BITS-1:0]     product;

    function automatic result_t make_result(
        input kind_t                   kind,
        input logic [LINE_BITS-1:0]    line,
        input logic [OFFSET_BITS-1:0]  offset,
        input logic [LENGTH_BITS-1:0]  length,
        input logic [NUMBER_BITS-1:0]  value,
        input err_t                    error
    );
        result_t r;
        r.kind   = kind;
        r.line   = line;
        r.offset = offset;
        r.length = length;
        r.value  = value;
        r.error  = error;
        return r;
    endfunction

    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7A))
                   || ((text_byte >= 8'h41) && (text_byte <= 8'h5A))
                   || (text_byte == 8'h5F) || text_byte[7];

    // The first live keyword whose full length has been seen names the word.
    always_comb
    begin
        kw_kind = KIND_IDENT;
        for (int k = KEYWORDS - 1; k >= 0; k--)
        begin
            if (alive_reg[k] && (run_reg == LENGTH_BITS'(KW_BYTES[k])))
            begin
                kw_kind = KIND_KW_BASE + KIND_BITS'(k);
            end
        end
    end

    always_comb
    begin
        punct_hit  = 1'b1;
        punct_kind = KIND_ERROR;
        case (text_byte)
            8'h2E:   punct_kind = KIND_PERIOD;
            8'h3D:   punct_kind = KIND_EQUAL;
            8'h2C:   punct_kind = KIND_COMMA;
            8'h3B:   punct_kind = KIND_SEMICOLON;
            8'h23:   punct_kind = KIND_HASH;
            8'h3C:   punct_kind = KIND_LESS;
            8'h3E:   punct_kind = KIND_GREATER;
            8'h2B:   punct_kind = KIND_PLUS;
            8'h2D:   punct_kind = KIND_MINUS;
            8'h2A:   punct_kind = KIND_TIMES;
            8'h2F:   punct_kind = KIND_SLASH;
            8'h28:   punct_kind = KIND_LPAREN;
            8'h29:   punct_kind = KIND_RPAREN;
            default: punct_hit  = 1'b0;
        endcase
    end

    // Mode decisions for the byte: first close any pending token, then treat
    // the byte again as a fresh byte unless the closing step used it up.
    always_comb
    begin
        consumed    = 1'b0;
        fresh       = 1'b0;
        take_ident  = 1'b0;
        take_number = 1'b0;
        restart     = 1'b0;
        new_line    = 1'b0;
        p1_valid    = 1'b0;
        p2_valid    = 1'b0;
        p2_pair     = 1'b0;
        p1_res      = '0;
        p2_res_a    = '0;
        p2_res_b    = '0;
        mode_mid    = mode_reg;
        start_next  = start_reg;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_alpha || is_digit)
                begin
                    take_ident = 1'b1;
                end
                else
                begin
                    p1_valid = 1'b1;
                    p1_res   = make_result(kw_kind, line_reg, start_reg, run_reg, '0, ERR_NONE);
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit)
                begin
                    take_number = 1'b1;
                end
                else if (ovf_reg)
                begin
                    p1_valid = 1'b1;
                    p1_res   = make_result(KIND_ERROR, line_reg, start_reg, run_reg, '0,
                                           ERR_OVERFLOW);
                    mode_mid = MODE_ERROR;
                end
                else
                begin
                    p1_valid = 1'b1;
                    p1_res   = make_result(KIND_NUMBER, line_reg, start_reg, run_reg,
                                           accum_reg, ERR_NONE);
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_COLON:
            begin
                p1_valid = 1'b1;
                if (text_byte == CH_EQUAL)
                begin
                    p1_res   = make_result(KIND_ASSIGN, line_reg, start_reg, LEN_TWO, '0,
                                           ERR_NONE);
                    mode_mid = MODE_IDLE;
                    consumed = 1'b1;
                end
                else
                begin
                    p1_res   = make_result(KIND_ERROR, line_reg, start_reg, LEN_ONE, '0,
                                           ERR_BAD_COLON);
                    mode_mid = MODE_ERROR;
                end
            end
            default:
            begin
            end
        endcase

        mode_next = mode_mid;

        if (!consumed && (mode_mid != MODE_IDENT) && (mode_mid != MODE_NUMBER))
        begin
            case (mode_mid)
                MODE_COMMENT:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        p2_valid = 1'b1;
                        p2_pair  = 1'b1;
                        p2_res_a = make_result(KIND_ERROR, line_reg, start_reg, '0, '0,
                                               ERR_OPEN_COMMENT);
                        p2_res_b = make_result(KIND_END, line_reg, pos_reg, '0, '0, ERR_NONE);
                        restart  = 1'b1;
                    end
                    else if (text_byte == CH_RBRACE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte == CH_LF)
                    begin
                        new_line = 1'b1;
                    end
                end
                MODE_ERROR:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        p2_valid = 1'b1;
                        p2_res_a = make_result(KIND_END, line_reg, pos_reg, '0, '0, ERR_NONE);
                        restart  = 1'b1;
                    end
                    else if (text_byte == CH_LF)
                    begin
                        new_line = 1'b1;
                    end
                end
                default:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        p2_valid = 1'b1;
                        p2_res_a = make_result(KIND_END, line_reg, pos_reg, '0, '0, ERR_NONE);
                        restart  = 1'b1;
                    end
                    else if ((text_byte == CH_SPACE) || (text_byte == CH_TAB))
                    begin
                    end
                    else if (text_byte == CH_LF)
                    begin
                        new_line = 1'b1;
                    end
                    else if (text_byte == CH_LBRACE)
                    begin
                        mode_next  = MODE_COMMENT;
                        start_next = pos_reg;
                    end
                    else if (text_byte == CH_COLON)
                    begin
                        mode_next  = MODE_COLON;
                        start_next = pos_reg;
                    end
                    else if (is_digit)
                    begin
                        mode_next   = MODE_NUMBER;
                        start_next  = pos_reg;
                        fresh       = 1'b1;
                        take_number = 1'b1;
                    end
                    else if (is_alpha)
                    begin
                        mode_next  = MODE_IDENT;
                        start_next = pos_reg;
                        fresh      = 1'b1;
                        take_ident = 1'b1;
                    end
                    else if (punct_hit)
                    begin
                        p2_valid = 1'b1;
                        p2_res_a = make_result(punct_kind, line_reg, pos_reg, LEN_ONE, '0,
                                               ERR_NONE);
                    end
                    else
                    begin
                        p2_valid  = 1'b1;
                        p2_res_a  = make_result(KIND_ERROR, line_reg, pos_reg, LEN_ONE, '0,
                                                ERR_UNKNOWN_BYTE);
                        mode_next = MODE_ERROR;
                    end
                end
            endcase
        end
    end

    // A token that starts on this byte begins from cleared counters.
    assign run_base   = fresh ? '0 : run_reg;
    assign ci_base    = fresh ? '0 : ci_reg;
    assign ph_base    = fresh ? '0 : ph_reg;
    assign alive_base = fresh ? '1 : alive_reg;
    assign accum_base = fresh ? '0 : accum_reg;

    // One compare per keyword against the byte expected at this position.
    always_comb
    begin
        kw_char_t   ch;
        logic [7:0] expect_byte;
        for (int k = 0; k < KEYWORDS; k++)
        begin
            ch = KW_CHARS[k][ci_base];
            case (ph_base)
                2'd0:    expect_byte = 8'hE0;
                2'd1:    expect_byte = 8'hA4 + {7'd0, ch[6]};
                default: expect_byte = {2'b10, ch[5:0]};
            endcase
            kw_match[k] = (run_base < LENGTH_BITS'(KW_BYTES[k])) && (expect_byte == text_byte);
        end
    end

    // Digit step: overflow exactly when ten times the value plus the digit
    // exceeds the largest number.
    assign product = ({4'd0, accum_base} << 3) + ({4'd0, accum_base} << 1)
                   + {{(PROD_BITS-4){1'b0}}, text_byte[3:0]};

    always_comb
    begin
        alive_next = alive_reg;
        run_next   = run_reg;
        ci_next    = ci_reg;
        ph_next    = ph_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        line_next  = line_reg;
        pos_next   = pos_reg;

        if (take_ident || take_number)
        begin
            run_next = (run_base < LEN_MAX) ? run_base + LEN_ONE : run_base;
        end

        if (take_ident)
        begin
            alive_next = alive_base & kw_match;
            if (ph_base == 2'd2)
            begin
                ph_next = 2'd0;
                ci_next = (ci_base == CI_LAST) ? ci_base : ci_base + KW_CHAR_BITS'(1);
            end
            else
            begin
                ph_next = ph_base + 2'd1;
                ci_next = ci_base;
            end
        end

        if (take_number)
        begin
            ovf_next   = fresh ? 1'b0 : ovf_reg;
            accum_next = accum_base;
            if (product > {4'd0, {NUMBER_BITS{1'b1}}})
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                accum_next = product[NUMBER_BITS-1:0];
            end
        end

        if (new_line && (line_reg != '1))
        begin
            line_next = line_reg + LINE_ONE;
        end

        if (pos_reg != '1)
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
        end
    end

    always_comb
    begin
        if (p1_valid)
        begin
            entry.first  = p1_res;
            entry.second = p2_res_a;
            entry.pair   = p2_valid;
        end
        else
        begin
            entry.first  = p2_res_a;
            entry.second = p2_res_b;
            entry.pair   = p2_pair;
        end
        count = 2'(p1_valid) + 2'(p2_valid) + 2'(p2_pair);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            alive_reg <= '1;
            run_reg   <= '0;
            ci_reg    <= '0;
            ph_reg    <= '0;
            accum_reg <= '0;
            ovf_reg   <= 1'b0;
            line_reg  <= LINE_ONE;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else if (step)
        begin
            if (restart)
            begin
                mode_reg  <= MODE_IDLE;
                alive_reg <= '1;
                run_reg   <= '0;
                ci_reg    <= '0;
                ph_reg    <= '0;
                accum_reg <= '0;
                ovf_reg   <= 1'b0;
                line_reg  <= LINE_ONE;
                pos_reg   <= '0;
                start_reg <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                alive_reg <= alive_next;
                run_reg   <= run_next;
                ci_reg    <= ci_next;
                ph_reg    <= ph_next;
                accum_reg <= accum_next;
                ovf_reg   <= ovf_next;
                line_reg  <= line_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
            end
        end
    end

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER)) |-> (run_reg != '0))
        else $error("identifier or number in progress with zero length");

    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (text_byte == CH_NUL)) |-> (count != 2'd0))
        else $error("end of text produced no result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (text_byte == CH_NUL))
            |=> ((mode_reg == MODE_IDLE) && (line_reg == LINE_ONE) && (pos_reg == '0)))
        else $error("scanner state not cleared after end of text");

endmodule

// ===== sv/pl0bt_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0bt_outq
// Two-entry result queue. Each entry holds all results of one byte; a pair
// is sent as two words, the second flagged as the last of its byte.
// ----------------------------------------------------------------------------
module pl0bt_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pl0bt_pkg::entry_t  push_entry,
    output logic               room,
    output logic               valid,
    input  logic               stall,
    output pl0bt_pkg::result_t result,
    output logic               last
);
    import pl0bt_pkg::*;

    entry_t     slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       sub_reg,    sub_next;
    entry_t     head;
    logic       pop_word, pop_entry;

    assign head      = slots_reg[rd_ptr_reg];
    assign valid     = (count_reg != 2'd0);
    assign result    = sub_reg ? head.second : head.first;
    assign last      = !head.pair || sub_reg;
    assign pop_word  = valid && !stall;
    assign pop_entry = pop_word && last;
    assign room      = (count_reg != 2'd2) || pop_entry;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_entry ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop_entry);
        if (pop_entry)
        begin
            sub_next = 1'b0;
        end
        else if (pop_word)
        begin
            sub_next = 1'b1;
        end
        else
        begin
            sub_next = sub_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((count_reg != 2'd2) || pop_entry))
        else $error("result queue written while full");

    a_sub_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> ((count_reg != 2'd0) && head.pair))
        else $error("second word selected for an entry without one");

endmodule

// ===== sv/pl0_byte_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0_byte_tokenizer_unit
// PL/0 tokenizer taking one source byte per word and giving token words
// with kind, line, offset, length, number value and error code.
// ----------------------------------------------------------------------------
//  Port group   Dir  Handshake                 Word
//  text         in   text_valid / text_stall   text_byte
//  token        out  token_valid / token_stall token_kind .. last_of_run
//
//  One byte is taken every cycle while text_stall is low; a byte with two
//  results, such as one that closes a token and starts or ends another, is
//  sent as two words on the token port. A taken byte is registered, then
//  decoded and written to the result queue, which offers its first word.
//  Throughput is set by the two-entry result queue: text_stall rises only
//  while the queue cannot take the decoded byte's results.
//  Reset is asynchronous and returns the scanner to line 1, offset 0.
// ----------------------------------------------------------------------------
module pl0_byte_tokenizer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             text_valid,
    output logic                             text_stall,
    input  logic [7:0]                       text_byte,
    output logic                             token_valid,
    input  logic                             token_stall,
    output logic [pl0bt_pkg::KIND_BITS-1:0]   token_kind,
    output logic [pl0bt_pkg::LINE_BITS-1:0]   line_number,
    output logic [pl0bt_pkg::OFFSET_BITS-1:0] token_offset,
    output logic [pl0bt_pkg::LENGTH_BITS-1:0] token_length,
    output logic [pl0bt_pkg::NUMBER_BITS-1:0] number_value,
    output logic [pl0bt_pkg::ERROR_BITS-1:0]  error_code,
    output logic                             last_of_run
);
    import pl0bt_pkg::*;

    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg,       byte_next;
    logic       step, accept, room, push;
    logic [1:0] res_count;
    entry_t     entry;
    result_t    result;

    assign step       = byte_valid_reg && ((res_count == 2'd0) || room);
    assign push       = step && (res_count != 2'd0);
    assign text_stall = byte_valid_reg && !step;
    assign accept     = text_valid && !text_stall;

    assign byte_valid_next = accept || (byte_valid_reg && !step);
    assign byte_next       = accept ? text_byte : byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    pl0bt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (byte_reg),
        .entry     (entry),
        .count     (res_count)
    );

    pl0bt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .room       (room),
        .valid      (token_valid),
        .stall      (token_stall),
        .result     (result),
        .last       (last_of_run)
    );

    assign token_kind   = result.kind;
    assign line_number  = result.line;
    assign token_offset = result.offset;
    assign token_length = result.length;
    assign number_value = result.value;
    assign error_code   = result.error;

endmodule
